@@ hw/rtl/packet_header_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packet header parser
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_PARSER_MACROS_SVH
`define PACKET_HEADER_PARSER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define PHP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/php_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet header parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package php_pkg;

  // Frame layout.
  localparam int HEADER_BYTES = 26;
  localparam int OFS_VERSION  = 4;
  localparam int OFS_TYPE     = 5;
  localparam int OFS_FLAGS    = 6;
  localparam int OFS_CHANNEL  = 7;
  localparam int OFS_SENDER   = 8;
  localparam int OFS_SESSION  = 14;
  localparam int OFS_SEQUENCE = 18;
  localparam int OFS_STAMP    = 20;
  localparam int OFS_LENGTH   = 24;

  // Byte counter.
  localparam int COUNT_BITS    = 11;
  localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;
  localparam int SAT_CEILING   = 1025;
  localparam int COUNT_SAT_INT = (COUNT_MAX < SAT_CEILING) ? COUNT_MAX : SAT_CEILING;
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = COUNT_BITS'(COUNT_SAT_INT);

  // Field widths.
  localparam int SIZE_BITS   = 11;
  localparam int LENGTH_BITS = 16;
  localparam int WIDE_BITS   = LENGTH_BITS + 1;

  // Checks.
  localparam int TYPE_SPAN           = 4;
  localparam int CHANNEL_MIN         = 1;
  localparam int CHANNEL_MAX         = 4;
  localparam int CLAIM_PAYLOAD_BYTES = 4;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAGIC_WORD       = 3'd0,
    REG_PROTOCOL_VERSION = 3'd1,
    REG_MAX_FRAME_SIZE   = 3'd2,
    REG_HEARTBEAT_SIZE   = 3'd3,
    REG_AUDIO_SIZE       = 3'd4,
    REG_TYPE_BASE        = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_SHORT   = 4'd1,
    ST_LARGE   = 4'd2,
    ST_MAGIC   = 4'd3,
    ST_VERSION = 4'd4,
    ST_TYPE    = 4'd5,
    ST_CHANNEL = 4'd6,
    ST_LENGTH  = 4'd7,
    ST_PAYLOAD = 4'd8
  } status_t;

  // Message kinds relative to the configured type base.
  typedef enum logic [2:0] {
    KIND_HEARTBEAT = 3'd0,
    KIND_CLAIM     = 3'd1,
    KIND_START     = 3'd2,
    KIND_AUDIO     = 3'd3,
    KIND_END       = 3'd4
  } kind_t;

  typedef struct packed {
    logic [31:0]          magic_word;
    logic [7:0]           protocol_version;
    logic [SIZE_BITS-1:0] max_frame_size;
    logic [SIZE_BITS-1:0] heartbeat_payload_size;
    logic [SIZE_BITS-1:0] audio_payload_size;
    logic [7:0]           type_base;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    magic_word:             32'd0,
    protocol_version:       8'd1,
    max_frame_size:         SIZE_BITS'(250),
    heartbeat_payload_size: SIZE_BITS'(19),
    audio_payload_size:     SIZE_BITS'(200),
    type_base:              8'd1
  };

  typedef struct packed {
    logic [31:0]            magic;
    logic [7:0]             version;
    logic [7:0]             message_type;
    logic [7:0]             flag_bits;
    logic [7:0]             channel_number;
    logic [47:0]            sender;
    logic [31:0]            session;
    logic [15:0]            sequence_number;
    logic [31:0]            time_stamp;
    logic [LENGTH_BITS-1:0] payload_bytes;
  } header_t;

  // A finished frame as handed from the capture stage to the judge stage.
  typedef struct packed {
    logic [COUNT_BITS-1:0] size;
    header_t               hdr;
  } frame_t;

  typedef struct packed {
    status_t                status;
    logic [7:0]             message_type;
    logic [7:0]             flag_bits;
    logic [7:0]             channel_number;
    logic [47:0]            sender;
    logic [31:0]            session;
    logic [15:0]            sequence_number;
    logic [31:0]            time_stamp;
    logic [LENGTH_BITS-1:0] payload_bytes;
  } result_t;

  // Handshake between the capture and judge stages.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } snap_t;

endpackage

@@ hw/rtl/php_in_if.sv @@
// ----------------------------------------------------------------------------
// Packet header parser byte channel
// One frame byte per beat, with a flag on the last byte of the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface php_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/php_out_if.sv @@
// ----------------------------------------------------------------------------
// Packet header parser result channel
// One status and decoded header per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface php_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  message_type;
  logic [7:0]  flag_bits;
  logic [7:0]  channel_number;
  logic [47:0] sender;
  logic [31:0] session;
  logic [15:0] sequence_number;
  logic [31:0] time_stamp;
  logic [15:0] payload_bytes;

  modport source (output valid, output status, output message_type, output flag_bits,
                  output channel_number, output sender, output session,
                  output sequence_number, output time_stamp, output payload_bytes,
                  input ready);
  modport sink   (input valid, input status, input message_type, input flag_bits,
                  input channel_number, input sender, input session,
                  input sequence_number, input time_stamp, input payload_bytes,
                  output ready);
endinterface

@@ hw/rtl/php_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Packet header parser configuration channel
// One register write per beat: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface php_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/php_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Packet header parser configuration registers
// Holds the expected header values and size limits; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module php_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  php_cfg_if.sink       cfg_if,
  output php_pkg::cfg_t cfg
);

  php_pkg::cfg_t cfg_r;
  php_pkg::cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (php_pkg::cfg_reg_t'(cfg_if.index))
        php_pkg::REG_MAGIC_WORD:       cfg_nxt.magic_word = cfg_if.data;
        php_pkg::REG_PROTOCOL_VERSION: cfg_nxt.protocol_version = cfg_if.data[7:0];
        php_pkg::REG_MAX_FRAME_SIZE:
          cfg_nxt.max_frame_size = cfg_if.data[php_pkg::SIZE_BITS-1:0];
        php_pkg::REG_HEARTBEAT_SIZE:
          cfg_nxt.heartbeat_payload_size = cfg_if.data[php_pkg::SIZE_BITS-1:0];
        php_pkg::REG_AUDIO_SIZE:
          cfg_nxt.audio_payload_size = cfg_if.data[php_pkg::SIZE_BITS-1:0];
        php_pkg::REG_TYPE_BASE:        cfg_nxt.type_base = cfg_if.data[7:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= php_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/php_capture.sv @@
// ----------------------------------------------------------------------------
// Packet header parser capture stage
// Counts frame bytes and shifts header bytes into their fields; on the
// last byte the completed frame is registered for the judge stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_header_parser_macros.svh"

module php_capture (
  input  logic           clk,
  input  logic           rst_n,
  php_in_if.sink         in_if,
  input  logic           snap_take,
  output php_pkg::snap_t snap
);

  logic [php_pkg::COUNT_BITS-1:0] count_r;
  logic [php_pkg::COUNT_BITS-1:0] count_nxt;
  php_pkg::header_t               hdr_r;
  php_pkg::header_t               hdr_nxt;
  logic                           snap_valid_r;
  logic                           snap_valid_nxt;
  php_pkg::frame_t                snap_r;
  php_pkg::frame_t                snap_nxt;
  logic                           accept;
  logic                           end_of_frame;
  logic [php_pkg::COUNT_BITS-1:0] pos;
  logic [7:0]                     b;
  php_pkg::header_t               hdr_upd;
  logic [php_pkg::COUNT_BITS-1:0] count_upd;

  // The snapshot register frees up in the same cycle the judge stage takes it.
  assign in_if.ready  = !snap_valid_r || snap_take;
  assign accept       = in_if.valid && in_if.ready;
  assign end_of_frame = accept && in_if.last_byte;
  assign pos          = count_r;
  assign b            = in_if.data_byte;

  // Header state with the current byte applied at its position.
  always_comb begin
    hdr_upd = hdr_r;
    if (pos < php_pkg::COUNT_BITS'(php_pkg::OFS_VERSION)) begin
      hdr_upd.magic = {hdr_r.magic[23:0], b};
    end else if (pos == php_pkg::COUNT_BITS'(php_pkg::OFS_VERSION)) begin
      hdr_upd.version = b;
    end else if (pos == php_pkg::COUNT_BITS'(php_pkg::OFS_TYPE)) begin
      hdr_upd.message_type = b;
    end else if (pos == php_pkg::COUNT_BITS'(php_pkg::OFS_FLAGS)) begin
      hdr_upd.flag_bits = b;
    end else if (pos == php_pkg::COUNT_BITS'(php_pkg::OFS_CHANNEL)) begin
      hdr_upd.channel_number = b;
    end else if (pos < php_pkg::COUNT_BITS'(php_pkg::OFS_SESSION)) begin
      hdr_upd.sender = {hdr_r.sender[39:0], b};
    end else if (pos < php_pkg::COUNT_BITS'(php_pkg::OFS_SEQUENCE)) begin
      hdr_upd.session = {hdr_r.session[23:0], b};
    end else if (pos < php_pkg::COUNT_BITS'(php_pkg::OFS_STAMP)) begin
      hdr_upd.sequence_number = {hdr_r.sequence_number[7:0], b};
    end else if (pos < php_pkg::COUNT_BITS'(php_pkg::OFS_LENGTH)) begin
      hdr_upd.time_stamp = {hdr_r.time_stamp[23:0], b};
    end else if (pos < php_pkg::COUNT_BITS'(php_pkg::HEADER_BYTES)) begin
      hdr_upd.payload_bytes = {hdr_r.payload_bytes[7:0], b};
    end
    count_upd = (count_r < php_pkg::COUNT_SAT) ? count_r + 1'b1 : count_r;
  end

  always_comb begin
    count_nxt      = count_r;
    hdr_nxt        = hdr_r;
    snap_valid_nxt = snap_valid_r;
    snap_nxt       = snap_r;
    if (snap_take) begin
      snap_valid_nxt = 1'b0;
    end
    if (end_of_frame) begin
      count_nxt      = '0;
      hdr_nxt        = '0;
      snap_valid_nxt = 1'b1;
      snap_nxt.size  = count_upd;
      snap_nxt.hdr   = hdr_upd;
    end else if (accept) begin
      count_nxt = count_upd;
      hdr_nxt   = hdr_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      hdr_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      hdr_r        <= hdr_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap.valid = snap_valid_r;
  assign snap.frame = snap_r;

  `PHP_ASSERT(a_count_cleared, end_of_frame |=> count_r == '0, "count not cleared after frame")
  `PHP_ASSERT(a_snap_held, snap_valid_r && !snap_take |=> snap_valid_r && $stable(snap_r), "waiting frame lost or changed")

endmodule

@@ hw/rtl/php_judge.sv @@
// ----------------------------------------------------------------------------
// Packet header parser judge stage
// Checks a completed frame against the configuration and registers the
// status and header fields for the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_header_parser_macros.svh"

module php_judge (
  input  logic           clk,
  input  logic           rst_n,
  input  php_pkg::cfg_t  cfg,
  input  php_pkg::snap_t snap,
  output logic           snap_take,
  php_out_if.source      out_if
);

  localparam int WB = php_pkg::WIDE_BITS;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  php_pkg::result_t                out_r;
  php_pkg::result_t                out_nxt;
  php_pkg::result_t                res;
  php_pkg::status_t                status;
  php_pkg::header_t                hdr;
  php_pkg::kind_t                  kind;
  logic [WB-1:0]                   size_w;
  logic [8:0]                      type_w;
  logic [8:0]                      base_w;
  logic [7:0]                      kind_diff;
  logic [php_pkg::LENGTH_BITS-1:0] need;

  assign snap_take = !out_valid_r || out_if.ready;
  assign hdr       = snap.frame.hdr;
  assign size_w    = WB'(snap.frame.size);
  assign type_w    = {1'b0, hdr.message_type};
  assign base_w    = {1'b0, cfg.type_base};
  assign kind_diff = hdr.message_type - cfg.type_base;
  assign kind      = php_pkg::kind_t'(kind_diff[2:0]);

  always_comb begin
    case (kind)
      php_pkg::KIND_HEARTBEAT: need = php_pkg::LENGTH_BITS'(cfg.heartbeat_payload_size);
      php_pkg::KIND_CLAIM:     need = php_pkg::LENGTH_BITS'(php_pkg::CLAIM_PAYLOAD_BYTES);
      php_pkg::KIND_AUDIO:     need = php_pkg::LENGTH_BITS'(cfg.audio_payload_size);
      default:                 need = '0;
    endcase
  end

  // Checks in priority order; the first failing one sets the status.
  always_comb begin
    if (size_w < WB'(php_pkg::HEADER_BYTES)) begin
      status = php_pkg::ST_SHORT;
    end else if (size_w > WB'(cfg.max_frame_size)) begin
      status = php_pkg::ST_LARGE;
    end else if (hdr.magic != cfg.magic_word) begin
      status = php_pkg::ST_MAGIC;
    end else if (hdr.version != cfg.protocol_version) begin
      status = php_pkg::ST_VERSION;
    end else if (type_w < base_w || type_w > base_w + 9'(php_pkg::TYPE_SPAN)) begin
      status = php_pkg::ST_TYPE;
    end else if (hdr.channel_number < 8'(php_pkg::CHANNEL_MIN) ||
                 hdr.channel_number > 8'(php_pkg::CHANNEL_MAX)) begin
      status = php_pkg::ST_CHANNEL;
    end else if (size_w != WB'(php_pkg::HEADER_BYTES) + WB'(hdr.payload_bytes)) begin
      status = php_pkg::ST_LENGTH;
    end else if (hdr.payload_bytes != need) begin
      status = php_pkg::ST_PAYLOAD;
    end else begin
      status = php_pkg::ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == php_pkg::ST_OK) begin
      res.message_type    = hdr.message_type;
      res.flag_bits       = hdr.flag_bits;
      res.channel_number  = hdr.channel_number;
      res.sender          = hdr.sender;
      res.session         = hdr.session;
      res.sequence_number = hdr.sequence_number;
      res.time_stamp      = hdr.time_stamp;
      res.payload_bytes   = hdr.payload_bytes;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (snap_take) begin
      out_valid_nxt = snap.valid;
      if (snap.valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_r.status;
  assign out_if.message_type    = out_r.message_type;
  assign out_if.flag_bits       = out_r.flag_bits;
  assign out_if.channel_number  = out_r.channel_number;
  assign out_if.sender          = out_r.sender;
  assign out_if.session         = out_r.session;
  assign out_if.sequence_number = out_r.sequence_number;
  assign out_if.time_stamp      = out_r.time_stamp;
  assign out_if.payload_bytes   = out_r.payload_bytes;

  `PHP_ASSERT(a_frame_moves, snap.valid && snap_take |=> out_valid_r, "taken frame gave no result")
  `PHP_ASSERT_NEVER(a_error_zeroed, out_valid_r && out_r.status != php_pkg::ST_OK && (out_r.sender != '0 || out_r.session != '0 || out_r.payload_bytes != '0 || out_r.message_type != '0), "error result carries header fields")

endmodule

@@ hw/rtl/packet_header_parser.sv @@
// ----------------------------------------------------------------------------
// Packet header parser
// Byte-wide frame receiver that decodes and checks a 26-byte header.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per beat on in_if, the last byte of each
// frame flagged by last_byte, and gives one result beat on out_if per frame.
// It sustains one byte per clock cycle while in_if.ready is high, with no
// gaps between frames: the only per-byte work is a saturating byte counter
// and a set of shift registers that capture the big-endian header fields at
// their offsets. When the last byte arrives the finished frame moves into a
// snapshot register, from which the judge stage registers the result, so
// with the output free a result is valid from the clock edge after the one
// that accepted its last byte. The checks run in a fixed order
// (too short, too large, magic, version, type, channel, length mismatch,
// payload size for the type) and the first failing one sets the status; on
// any error every header field of the result reads as zero. Payload bytes are
// counted but not forwarded. The counter stops at 1025, so longer frames are
// judged as 1025 bytes long. in_if.ready drops only when both the snapshot
// register and the output register hold frames and the result is not being
// taken. Configuration writes on cfg_if are always accepted and should be
// made only while no frame is in progress or waiting; writes to indexes
// outside the register list are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_header_parser (
  input  logic      clk,
  input  logic      rst_n,
  php_in_if.sink    in_if,
  php_out_if.source out_if,
  php_cfg_if.sink   cfg_if
);

  // Register file: magic, version, size limits and the base type code.
  php_pkg::cfg_t  cfg;
  // Completed frame waiting for the judge stage, and its take strobe.
  php_pkg::snap_t snap;
  logic           snap_take;

  php_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Byte counting and header field capture, one byte per cycle while in_if.ready is high.
  php_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .snap_take (snap_take),
    .snap      (snap)
  );

  // Header checks and the output register.
  php_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .snap      (snap),
    .snap_take (snap_take),
    .out_if    (out_if)
  );

endmodule

@@ tb/packet_header_parser_tb.sv @@
// ----------------------------------------------------------------------------
// Packet header parser testbench
// Feeds whole frames a byte per beat and checks every result beat against an
// independent model of the header capture and the ordered status checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_header_parser_tb;

  // Ways in which a generated frame departs from a well-formed one. F_RAW is
  // a bare header made of one repeated byte, F_NOISE is random bytes of a
  // random length, F_LONG runs past the point where the byte counter stops.
  typedef enum logic [3:0] {
    F_NONE, F_SHORT, F_LARGE, F_MAGIC, F_VERSION, F_TYPE, F_CHANNEL,
    F_LENGTH, F_PAYLOAD, F_LONG, F_RAW, F_NOISE
  } fault_t;

  // What goes into the header fields that no check looks at, and the payload.
  typedef enum logic [1:0] {
    FILL_RANDOM, FILL_ZEROS, FILL_ONES
  } fill_t;

  // One row of the directed table. Where typed is set the status is given
  // here and every other field of the result is zero; otherwise the result
  // comes from the model below.
  typedef struct packed {
    fault_t           fault;
    php_pkg::kind_t   kind;
    fill_t            fill;
    logic [10:0]      size;
    logic             typed;
    php_pkg::status_t want;
  } frame_row_t;

  // Indexes past the end of the register list; writes to them must be dropped.
  localparam logic [php_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [php_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

  logic clk;
  logic rst_n;

  php_in_if  in_if ();
  php_out_if out_if ();
  php_cfg_if cfg_if ();

  packet_header_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model state: the register copy, the byte count of the frame in progress
  // and the header captured so far, plus the results still to come out.
  // --------------------------------------------------------------------------
  php_pkg::cfg_t    parser_cfg;
  int               frame_len;
  php_pkg::header_t frame_hdr;
  php_pkg::result_t parsed_headers[$];
  logic [7:0]       frame_bytes[$];

  // Traffic shaping, set by the main sequence and read by the two sides.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_goal      = 0;
  int hold_done      = 0;

  int fail_count   = 0;
  int result_count = 0;
  int sent_bytes   = 0;
  int sent_frames  = 0;

  // The directed table. It runs with the registers as they come out of reset:
  // magic 0, version 1, largest frame 250, heartbeat payload 19, audio
  // payload 200, heartbeat code 1.
  frame_row_t directed_rows [21] = '{
    '{F_SHORT,   php_pkg::KIND_START,     FILL_ONES,   11'd1,  1'b1, php_pkg::ST_SHORT},
    '{F_SHORT,   php_pkg::KIND_START,     FILL_RANDOM, 11'd25, 1'b1, php_pkg::ST_SHORT},
    '{F_NONE,    php_pkg::KIND_START,     FILL_ZEROS,  11'd0,  1'b0, php_pkg::ST_OK},
    '{F_NONE,    php_pkg::KIND_END,       FILL_ONES,   11'd0,  1'b0, php_pkg::ST_OK},
    '{F_NONE,    php_pkg::KIND_CLAIM,     FILL_RANDOM, 11'd0,  1'b0, php_pkg::ST_OK},
    '{F_NONE,    php_pkg::KIND_HEARTBEAT, FILL_RANDOM, 11'd0,  1'b0, php_pkg::ST_OK},
    '{F_NONE,    php_pkg::KIND_AUDIO,     FILL_RANDOM, 11'd0,  1'b0, php_pkg::ST_OK},
    '{F_LARGE,   php_pkg::KIND_START,     FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_LARGE},
    '{F_MAGIC,   php_pkg::KIND_START,     FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_MAGIC},
    '{F_VERSION, php_pkg::KIND_END,       FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_VERSION},
    '{F_TYPE,    php_pkg::KIND_START,     FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_TYPE},
    '{F_TYPE,    php_pkg::KIND_CLAIM,     FILL_ONES,   11'd0,  1'b1, php_pkg::ST_TYPE},
    '{F_CHANNEL, php_pkg::KIND_START,     FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_CHANNEL},
    '{F_CHANNEL, php_pkg::KIND_HEARTBEAT, FILL_ZEROS,  11'd0,  1'b1, php_pkg::ST_CHANNEL},
    '{F_LENGTH,  php_pkg::KIND_START,     FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_LENGTH},
    '{F_LENGTH,  php_pkg::KIND_CLAIM,     FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_LENGTH},
    '{F_PAYLOAD, php_pkg::KIND_CLAIM,     FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_PAYLOAD},
    '{F_PAYLOAD, php_pkg::KIND_END,       FILL_RANDOM, 11'd0,  1'b1, php_pkg::ST_PAYLOAD},
    '{F_RAW,     php_pkg::KIND_START,     FILL_ZEROS,  11'd0,  1'b1, php_pkg::ST_VERSION},
    '{F_RAW,     php_pkg::KIND_START,     FILL_ONES,   11'd0,  1'b1, php_pkg::ST_MAGIC},
    '{F_NOISE,   php_pkg::KIND_START,     FILL_RANDOM, 11'd0,  1'b0, php_pkg::ST_OK}
  };

  // Payload length that a message kind must declare under the current setup.
  function automatic int required_payload(input php_pkg::kind_t k);
    case (k)
      php_pkg::KIND_HEARTBEAT: return int'(parser_cfg.heartbeat_payload_size);
      php_pkg::KIND_CLAIM:     return php_pkg::CLAIM_PAYLOAD_BYTES;
      php_pkg::KIND_AUDIO:     return int'(parser_cfg.audio_payload_size);
      default:                 return 0;
    endcase
  endfunction

  // The ordered checks on a finished frame; the first one to fail wins.
  function automatic php_pkg::status_t frame_status(input int size);
    int code;
    int base;
    code = int'(frame_hdr.message_type);
    base = int'(parser_cfg.type_base);
    if (size < php_pkg::HEADER_BYTES) return php_pkg::ST_SHORT;
    if (size > int'(parser_cfg.max_frame_size)) return php_pkg::ST_LARGE;
    if (frame_hdr.magic != parser_cfg.magic_word) return php_pkg::ST_MAGIC;
    if (frame_hdr.version != parser_cfg.protocol_version) return php_pkg::ST_VERSION;
    if (code < base || code > base + php_pkg::TYPE_SPAN) return php_pkg::ST_TYPE;
    if (int'(frame_hdr.channel_number) < php_pkg::CHANNEL_MIN ||
        int'(frame_hdr.channel_number) > php_pkg::CHANNEL_MAX) return php_pkg::ST_CHANNEL;
    if (size != php_pkg::HEADER_BYTES + int'(frame_hdr.payload_bytes))
      return php_pkg::ST_LENGTH;
    if (int'(frame_hdr.payload_bytes) != required_payload(php_pkg::kind_t'(code - base)))
      return php_pkg::ST_PAYLOAD;
    return php_pkg::ST_OK;
  endfunction

  // Takes one accepted byte into the model. On the last byte of a frame it
  // hands back the result and clears the frame state.
  task automatic parse_byte(input logic [7:0] b, input logic last, output bit done,
                            output php_pkg::result_t res);
    php_pkg::status_t st;
    if (frame_len < php_pkg::OFS_VERSION) frame_hdr.magic = {frame_hdr.magic[23:0], b};
    else if (frame_len == php_pkg::OFS_VERSION) frame_hdr.version = b;
    else if (frame_len == php_pkg::OFS_TYPE) frame_hdr.message_type = b;
    else if (frame_len == php_pkg::OFS_FLAGS) frame_hdr.flag_bits = b;
    else if (frame_len == php_pkg::OFS_CHANNEL) frame_hdr.channel_number = b;
    else if (frame_len < php_pkg::OFS_SESSION)
      frame_hdr.sender = {frame_hdr.sender[39:0], b};
    else if (frame_len < php_pkg::OFS_SEQUENCE)
      frame_hdr.session = {frame_hdr.session[23:0], b};
    else if (frame_len < php_pkg::OFS_STAMP)
      frame_hdr.sequence_number = {frame_hdr.sequence_number[7:0], b};
    else if (frame_len < php_pkg::OFS_LENGTH)
      frame_hdr.time_stamp = {frame_hdr.time_stamp[23:0], b};
    else if (frame_len < php_pkg::HEADER_BYTES)
      frame_hdr.payload_bytes = {frame_hdr.payload_bytes[7:0], b};
    if (frame_len < php_pkg::COUNT_SAT_INT) frame_len++;
    done = last;
    res  = '0;
    if (last) begin
      st = frame_status(frame_len);
      res.status = st;
      if (st == php_pkg::ST_OK) begin
        res.message_type    = frame_hdr.message_type;
        res.flag_bits       = frame_hdr.flag_bits;
        res.channel_number  = frame_hdr.channel_number;
        res.sender          = frame_hdr.sender;
        res.session         = frame_hdr.session;
        res.sequence_number = frame_hdr.sequence_number;
        res.time_stamp      = frame_hdr.time_stamp;
        res.payload_bytes   = frame_hdr.payload_bytes;
      end
      frame_len = 0;
      frame_hdr = '0;
    end
  endtask

  // Offers one byte, with random idle cycles ahead of it, and returns at the
  // clock edge where the beat is taken. Valid is only lowered in an idle
  // cycle, so back-to-back beats keep it high without a glitch.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // One register write. The caller lowers valid after its last write.
  task automatic write_reg(input logic [php_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [php_pkg::CFG_DATA_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      php_pkg::REG_MAGIC_WORD:       parser_cfg.magic_word       = value;
      php_pkg::REG_PROTOCOL_VERSION: parser_cfg.protocol_version = value[7:0];
      php_pkg::REG_MAX_FRAME_SIZE:
        parser_cfg.max_frame_size = value[php_pkg::SIZE_BITS-1:0];
      php_pkg::REG_HEARTBEAT_SIZE:
        parser_cfg.heartbeat_payload_size = value[php_pkg::SIZE_BITS-1:0];
      php_pkg::REG_AUDIO_SIZE:
        parser_cfg.audio_payload_size = value[php_pkg::SIZE_BITS-1:0];
      php_pkg::REG_TYPE_BASE:        parser_cfg.type_base        = value[7:0];
      default: ;
    endcase
  endtask

  // Writes the whole register set. The bits above each field's width carry
  // junk, which the block has to drop.
  task automatic write_all(input php_pkg::cfg_t c, input bit spare);
    logic [31:0] junk;
    junk = $urandom;
    if (spare) write_reg(REG_SPARE_A, $urandom);
    write_reg(php_pkg::REG_MAGIC_WORD, c.magic_word);
    write_reg(php_pkg::REG_PROTOCOL_VERSION, {junk[31:8], c.protocol_version});
    write_reg(php_pkg::REG_MAX_FRAME_SIZE, {junk[31:php_pkg::SIZE_BITS], c.max_frame_size});
    write_reg(php_pkg::REG_HEARTBEAT_SIZE,
              {junk[31:php_pkg::SIZE_BITS], c.heartbeat_payload_size});
    write_reg(php_pkg::REG_AUDIO_SIZE, {junk[31:php_pkg::SIZE_BITS], c.audio_payload_size});
    write_reg(php_pkg::REG_TYPE_BASE, {junk[31:8], c.type_base});
    if (spare) write_reg(REG_SPARE_B, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  // Builds a frame into frame_bytes: a well-formed frame for the current
  // setup, then bent by the fault asked for. len_hint fixes the length of
  // short and long frames where it is not zero.
  task automatic build_frame(input fault_t f, input php_pkg::kind_t k, input fill_t fill,
                             input int len_hint);
    php_pkg::header_t                   h;
    logic [8*php_pkg::HEADER_BYTES-1:0] hv;
    int                                 plen;
    int                                 size;
    int                                 i;
    frame_bytes.delete();
    if (f == F_NOISE) begin
      size = $urandom_range(1, 40);
      for (i = 0; i < size; i++) frame_bytes.push_back(8'($urandom_range(255)));
    end else if (f == F_RAW) begin
      for (i = 0; i < php_pkg::HEADER_BYTES; i++)
        frame_bytes.push_back((fill == FILL_ONES) ? 8'hFF : 8'h00);
    end else begin
      if (fill == FILL_ZEROS) begin
        h = '0;
      end else if (fill == FILL_ONES) begin
        h = '1;
      end else begin
        h.flag_bits       = 8'($urandom);
        h.sender          = 48'({$urandom, $urandom});
        h.session         = $urandom;
        h.sequence_number = 16'($urandom);
        h.time_stamp      = $urandom;
      end
      h.magic          = parser_cfg.magic_word;
      h.version        = parser_cfg.protocol_version;
      h.message_type   = parser_cfg.type_base + 8'(k);
      h.channel_number = 8'($urandom_range(php_pkg::CHANNEL_MIN, php_pkg::CHANNEL_MAX));
      plen = required_payload(k);
      case (f)
        F_LARGE: plen = int'(parser_cfg.max_frame_size) - php_pkg::HEADER_BYTES + 1 +
                        $urandom_range(3);
        F_PAYLOAD: begin
          if (plen > 0 && $urandom_range(1) == 0) plen = plen - 1;
          else plen = plen + 1 + $urandom_range(3);
        end
        F_LONG: plen = php_pkg::COUNT_SAT_INT - php_pkg::HEADER_BYTES;
        F_MAGIC: h.magic = h.magic ^ (32'd1 << $urandom_range(31));
        F_VERSION: h.version = h.version ^ (8'd1 << $urandom_range(7));
        F_TYPE: begin
          do h.message_type = 8'($urandom);
          while (int'(h.message_type) >= int'(parser_cfg.type_base) &&
                 int'(h.message_type) <= int'(parser_cfg.type_base) + php_pkg::TYPE_SPAN);
        end
        F_CHANNEL: begin
          do h.channel_number = 8'($urandom);
          while (int'(h.channel_number) >= php_pkg::CHANNEL_MIN &&
                 int'(h.channel_number) <= php_pkg::CHANNEL_MAX);
        end
        default: ;
      endcase
      h.payload_bytes = 16'(plen);
      if (f == F_LENGTH) begin
        if (plen > 0 && $urandom_range(1) == 0) h.payload_bytes = 16'(plen - 1);
        else h.payload_bytes = 16'(plen + 1 + $urandom_range(3));
      end
      size = php_pkg::HEADER_BYTES + plen;
      if (f == F_LONG)
        size = (len_hint > 0) ? len_hint : php_pkg::COUNT_SAT_INT + $urandom_range(1, 20);
      if (f == F_SHORT)
        size = (len_hint > 0) ? len_hint : $urandom_range(1, php_pkg::HEADER_BYTES - 1);
      hv = h;
      for (i = 0; i < size; i++) begin
        if (i < php_pkg::HEADER_BYTES)
          frame_bytes.push_back(hv[8*(php_pkg::HEADER_BYTES-1-i) +: 8]);
        else if (fill == FILL_ZEROS) frame_bytes.push_back(8'h00);
        else if (fill == FILL_ONES) frame_bytes.push_back(8'hFF);
        else frame_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Sends frame_bytes and queues what the result beat must hold.
  task automatic send_frame(input bit typed, input php_pkg::status_t want);
    bit               done;
    php_pkg::result_t res;
    int               i;
    for (i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      parse_byte(frame_bytes[i], i == frame_bytes.size() - 1, done, res);
      if (done) begin
        if (typed) begin
          res        = '0;
          res.status = want;
        end
        parsed_headers.push_back(res);
      end
      sent_bytes++;
    end
    sent_frames++;
  endtask

  // Mostly well-formed frames with random content, so that most of them get
  // through every check; the rest carry one fault each, or are plain noise.
  task automatic random_frame();
    int             r;
    php_pkg::kind_t k;
    fault_t         f;
    fill_t          fill;
    r = $urandom_range(99);
    k = php_pkg::kind_t'($urandom_range(php_pkg::KIND_END));
    // Keep the payload short when the setup asks for a big one.
    if (required_payload(k) > 100) k = php_pkg::KIND_START;
    if (r < 65) f = F_NONE;
    else if (r < 92) f = fault_t'($urandom_range(F_SHORT, F_PAYLOAD));
    else f = F_NOISE;
    if (f == F_LARGE && parser_cfg.max_frame_size > 300) f = F_NONE;
    r = $urandom_range(19);
    fill = (r == 0) ? FILL_ZEROS : (r == 1) ? FILL_ONES : FILL_RANDOM;
    build_frame(f, k, fill, 0);
    send_frame(1'b0, php_pkg::ST_OK);
  endtask

  // Waits until every queued result has come out, then lets the two pipeline
  // stages settle before the registers are touched.
  task automatic wait_idle();
    while (parsed_headers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One phase of random traffic under the current setup. hold sets how long the
  // result side refuses beats at the start, while the sender keeps pushing,
  // so the parser fills both stages and stops taking bytes.
  task automatic run_phase(input int send_pct, input int recv_pct, input int hold);
    int first_byte;
    int first_frame;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold > 0) hold_goal = hold_done + hold;
    first_byte  = sent_bytes;
    first_frame = sent_frames;
    while (sent_bytes - first_byte < 100 || sent_frames - first_frame < 4) random_frame();
    in_if.valid <= 1'b0;
    wait_idle();
  endtask

  task automatic random_setup(output php_pkg::cfg_t c);
    c.magic_word             = $urandom;
    c.protocol_version       = 8'($urandom);
    c.max_frame_size         = php_pkg::SIZE_BITS'($urandom_range(40, 300));
    c.heartbeat_payload_size = php_pkg::SIZE_BITS'($urandom_range(0, 30));
    c.audio_payload_size     = php_pkg::SIZE_BITS'($urandom_range(0, 60));
    c.type_base              = 8'($urandom_range(0, 251));
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d: %s expected %h, got %h", result_count, name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side. It samples at the clock edge, so it sees the values that the
  // beat was taken with, then picks ready for the next cycle: low throughout a
  // requested hold-off, otherwise at random by the current stall rate.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    php_pkg::result_t want;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        result_count++;
        if (parsed_headers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: beat with status %0d arrived with none due",
                     result_count, out_if.status);
        end else begin
          want = parsed_headers.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("message_type", want.message_type, out_if.message_type);
          check_field("flag_bits", want.flag_bits, out_if.flag_bits);
          check_field("channel_number", want.channel_number, out_if.channel_number);
          check_field("sender", want.sender, out_if.sender);
          check_field("session", want.session, out_if.session);
          check_field("sequence_number", want.sequence_number, out_if.sequence_number);
          check_field("time_stamp", want.time_stamp, out_if.time_stamp);
          check_field("payload_bytes", want.payload_bytes, out_if.payload_bytes);
        end
      end
      if (hold_done < hold_goal) begin
        hold_done++;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed table under the reset setup, then a
  // series of phases, each with its own register set and traffic shape.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    php_pkg::cfg_t c;
    int            i;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.last_byte  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = php_pkg::REG_MAGIC_WORD;
    cfg_if.data      = '0;
    parser_cfg       = php_pkg::CFG_RESET;
    frame_len        = 0;
    frame_hdr        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames, back to back with no idling on either side.
    for (i = 0; i < $size(directed_rows); i++) begin
      build_frame(directed_rows[i].fault, directed_rows[i].kind, directed_rows[i].fill,
                  int'(directed_rows[i].size));
      send_frame(directed_rows[i].typed, directed_rows[i].want);
    end
    in_if.valid <= 1'b0;
    wait_idle();

    // A random setup, with writes to the unused indexes around it; no idling.
    random_setup(c);
    write_all(c, 1'b1);
    run_phase(0, 0, 0);

    // Magic and version at their top, size registers at 1024, type codes at the very end of the byte range.
    c = '{32'hFFFF_FFFF, 8'hFF, php_pkg::SIZE_BITS'(1024), php_pkg::SIZE_BITS'(1024),
          php_pkg::SIZE_BITS'(1024), 8'd251};
    write_all(c, 1'b0);
    run_phase(73, 0, 0);

    // Every register at its bottom: only bare headers can be of legal size.
    c = '{32'h0000_0000, 8'h00, php_pkg::SIZE_BITS'(php_pkg::HEADER_BYTES),
          php_pkg::SIZE_BITS'(0), php_pkg::SIZE_BITS'(0), 8'd0};
    write_all(c, 1'b0);
    run_phase(0, 73, 0);

    random_setup(c);
    write_all(c, 1'b0);
    run_phase(15, 15, 0);

    // Largest frame size past its range, so that a frame longer than the
    // counter's stop is judged at the stop value and can still pass whole.
    random_setup(c);
    c.max_frame_size     = '1;
    c.audio_payload_size = php_pkg::SIZE_BITS'(php_pkg::COUNT_SAT_INT - php_pkg::HEADER_BYTES);
    write_all(c, 1'b1);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    build_frame(F_LONG, php_pkg::KIND_AUDIO, FILL_RANDOM, 0);
    send_frame(1'b0, php_pkg::ST_OK);
    in_if.valid <= 1'b0;
    wait_idle();

    // Back pressure: the result side holds off for a long stretch at the start.
    random_setup(c);
    write_all(c, 1'b0);
    run_phase(0, 0, 400);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin : watchdog
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
